@@ hw/rtl/voice_slot_allocator_assert.svh @@
// Assertion macros used by the voice slot allocator datapath.
`ifndef VOICE_SLOT_ALLOCATOR_ASSERT_SVH
`define VOICE_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Check on every clock edge outside reset
`define VSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included
`define VSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VSA_ASSERT(lbl, prop, msg)
`define VSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/vsa_pkg.sv @@
// Types, codes and constants of the voice slot allocator.
package vsa_pkg;

  localparam int VOICE_SLOTS_DEF = 32;
  localparam int FUNC_W          = 3;
  localparam int STATUS_W        = 3;
  localparam int SLOT_W          = 6;
  localparam int GEN_W           = 16;
  localparam int AGE_W           = 32;

  localparam logic [AGE_W-1:0] AGE_LIMIT = 32'hFFFF_FFFF;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_PLAY     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISHED = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP_ALL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CLIP  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALL_LOOP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STALE    = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              loop_flag;
    logic              clip_present;
    logic [SLOT_W-1:0] slot_index;
    logic [GEN_W-1:0]  handle_generation;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [GEN_W-1:0]    granted_generation;
    logic                stole_voice;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_req;
    logic scan_step;
    logic sweep_step;
    logic rd_pick;
    logic pick_commit;
    logic handle_commit;
    logic res_imm;
    logic res_fail;
    logic res_ok;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic play_go;
    logic stop_all;
    logic handle_ok;
    logic scan_done;
    logic pick_found;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/vsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module vsa_ram #(
  parameter int WIDTH = vsa_pkg::GEN_W,
  parameter int DEPTH = vsa_pkg::VOICE_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/vsa_ctrl.sv @@
// Sequencer of the voice slot allocator: one request at a time.
module vsa_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  vsa_pkg::sts_t sts,
  output vsa_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_PRD    = 3'd3;
  localparam logic [2:0] S_PWR    = 3'd4;
  localparam logic [2:0] S_HCHK   = 3'd5;
  localparam logic [2:0] S_SWEEP  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Decode state into datapath commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.rd_req = 1'b1;
        if (sts.play_go) begin
          state_nxt = S_SCAN;
        end else if (sts.stop_all) begin
          state_nxt = S_SWEEP;
        end else if (sts.handle_ok) begin
          state_nxt = S_HCHK;
        end else begin
          cmd.res_imm = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        if (sts.pick_found) begin
          cmd.rd_pick = 1'b1;
          state_nxt   = S_PWR;
        end else begin
          cmd.res_fail = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_PWR: begin
        cmd.pick_commit = 1'b1;
        state_nxt       = S_DONE;
      end
      S_HCHK: begin
        cmd.handle_commit = 1'b1;
        state_nxt         = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.scan_done) begin
          cmd.res_ok = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/vsa_dp.sv @@
// Datapath of the voice slot allocator: slot flags, age and generation stores.
`include "voice_slot_allocator_assert.svh"
module vsa_dp #(
  parameter int VOICE_SLOTS = vsa_pkg::VOICE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  vsa_pkg::in_beat_t   in_beat,
  input  logic                out_stall,
  output logic                out_valid,
  output vsa_pkg::out_beat_t  out_beat,
  input  vsa_pkg::cmd_t       cmd,
  output vsa_pkg::sts_t       sts
);

  localparam int IDX_W = $clog2(VOICE_SLOTS);
  localparam int CNT_W = $clog2(VOICE_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(VOICE_SLOTS);
  localparam logic [vsa_pkg::SLOT_W:0] SLOT_LIM = (vsa_pkg::SLOT_W + 1)'(VOICE_SLOTS);

  logic                       enabled_r;
  vsa_pkg::in_beat_t          req_r;
  logic [VOICE_SLOTS-1:0]     active_r;
  logic [VOICE_SLOTS-1:0]     loops_r;
  logic [VOICE_SLOTS-1:0]     gen_vld_r;
  logic [vsa_pkg::AGE_W-1:0]  play_cnt_r;
  logic [vsa_pkg::AGE_W-1:0]  play_cnt_nxt;
  logic [CNT_W-1:0]           scan_r;
  logic                       scan_vld_r;
  logic [IDX_W-1:0]           idx_r;
  logic                       free_found_r;
  logic [IDX_W-1:0]           free_idx_r;
  logic                       best_found_r;
  logic [IDX_W-1:0]           best_idx_r;
  logic [vsa_pkg::AGE_W-1:0]  best_age_r;
  vsa_pkg::out_beat_t         res_r;
  vsa_pkg::out_beat_t         out_r;
  logic                       out_valid_r;

  logic [IDX_W-1:0]           req_slot;
  logic                       slot_in_range;
  logic                       scan_more;
  logic [IDX_W-1:0]           pick_idx;
  logic [IDX_W-1:0]           rd_addr;
  logic                       rd_en;
  logic [vsa_pkg::GEN_W-1:0]  gen_q;
  logic [vsa_pkg::AGE_W-1:0]  age_q;
  logic [vsa_pkg::GEN_W-1:0]  gen_eff;
  logic [vsa_pkg::GEN_W-1:0]  gen_inc;
  logic                       gen_match;
  logic                       scan_eval;
  logic                       sweep_free;
  logic                       handle_free;
  logic                       stole;
  logic                       gen_we;
  logic [vsa_pkg::GEN_W-1:0]  gen_wdata;
  logic                       is_stop;
  logic                       is_query;
  logic                       is_fin;

  // Request decode
  assign req_slot      = req_r.slot_index[IDX_W-1:0];
  assign slot_in_range = ({1'b0, req_r.slot_index} < SLOT_LIM);
  assign is_stop       = (req_r.func == vsa_pkg::FUNC_STOP);
  assign is_query      = (req_r.func == vsa_pkg::FUNC_QUERY);
  assign is_fin        = (req_r.func == vsa_pkg::FUNC_FINISHED);

  assign sts.play_go    = (req_r.func == vsa_pkg::FUNC_PLAY) && enabled_r && req_r.clip_present;
  assign sts.stop_all   = (req_r.func == vsa_pkg::FUNC_STOP_ALL);
  assign sts.handle_ok  = (is_stop || is_query || is_fin) && slot_in_range && active_r[req_slot];
  assign sts.scan_done  = (scan_r == CNT_LIM) && !scan_vld_r;
  assign sts.pick_found = free_found_r || best_found_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Store read address: scan counter, chosen slot or handle slot
  assign scan_more = (scan_r < CNT_LIM);
  assign pick_idx  = free_found_r ? free_idx_r : best_idx_r;
  always_comb begin
    if (cmd.scan_step || cmd.sweep_step) begin
      rd_addr = scan_r[IDX_W-1:0];
    end else if (cmd.rd_pick) begin
      rd_addr = pick_idx;
    end else begin
      rd_addr = req_slot;
    end
  end
  assign rd_en = cmd.rd_req || cmd.rd_pick || ((cmd.scan_step || cmd.sweep_step) && scan_more);

  // Generation of the slot just read; never-written slots read as zero
  assign gen_eff   = gen_vld_r[idx_r] ? gen_q : '0;
  assign gen_inc   = gen_eff + 1'b1;
  assign gen_match = (gen_eff == req_r.handle_generation);

  assign scan_eval   = cmd.scan_step && scan_vld_r;
  assign sweep_free  = cmd.sweep_step && scan_vld_r && active_r[idx_r];
  assign handle_free = cmd.handle_commit &&
                       ((is_stop && gen_match) || (is_fin && !loops_r[idx_r]));
  assign stole        = !free_found_r;
  assign play_cnt_nxt = play_cnt_r + 1'b1;

  // Generation store write
  always_comb begin
    gen_we    = 1'b0;
    gen_wdata = gen_inc;
    if (cmd.pick_commit) begin
      gen_we    = 1'b1;
      gen_wdata = stole ? gen_inc : gen_eff;
    end else if (handle_free || sweep_free) begin
      gen_we = 1'b1;
    end
  end

  vsa_ram #(
    .WIDTH (vsa_pkg::GEN_W),
    .DEPTH (VOICE_SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (idx_r),
    .wdata (gen_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (gen_q)
  );

  vsa_ram #(
    .WIDTH (vsa_pkg::AGE_W),
    .DEPTH (VOICE_SLOTS)
  ) u_age_ram (
    .clk   (clk),
    .we    (cmd.pick_commit),
    .waddr (idx_r),
    .wdata (play_cnt_nxt),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (age_q)
  );

  // Config, slot flags, play counter and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      active_r   <= '0;
      loops_r    <= '0;
      gen_vld_r  <= '0;
      play_cnt_r <= '0;
      scan_r     <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        enabled_r <= cfg_wdata;
      end
      if (cmd.capture) begin
        scan_r     <= '0;
        scan_vld_r <= 1'b0;
      end else if (cmd.scan_step || cmd.sweep_step) begin
        scan_vld_r <= scan_more;
        if (scan_more) begin
          scan_r <= scan_r + 1'b1;
        end
      end
      if (cmd.pick_commit) begin
        active_r[idx_r]  <= 1'b1;
        loops_r[idx_r]   <= req_r.loop_flag;
        gen_vld_r[idx_r] <= 1'b1;
        play_cnt_r       <= play_cnt_nxt;
      end else if (handle_free || sweep_free) begin
        active_r[idx_r]  <= 1'b0;
        loops_r[idx_r]   <= 1'b0;
        gen_vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // Hold the request, track the read slot and the free and oldest candidates
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r        <= in_beat;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
      best_age_r   <= vsa_pkg::AGE_LIMIT;
    end else if (scan_eval) begin
      if (!active_r[idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
      if (active_r[idx_r] && !loops_r[idx_r] && (age_q < best_age_r)) begin
        best_found_r <= 1'b1;
        best_idx_r   <= idx_r;
        best_age_r   <= age_q;
      end
    end
    if (rd_en) begin
      idx_r <= rd_addr;
    end
  end

  // Build the result beat
  always_ff @(posedge clk) begin
    if (cmd.res_imm) begin
      res_r <= '0;
      if (req_r.func == vsa_pkg::FUNC_PLAY) begin
        res_r.status <= enabled_r ? vsa_pkg::ST_NO_CLIP : vsa_pkg::ST_DISABLED;
      end else if (is_stop || is_query) begin
        res_r.status <= vsa_pkg::ST_STALE;
      end
    end else if (cmd.res_fail) begin
      res_r        <= '0;
      res_r.status <= vsa_pkg::ST_ALL_LOOP;
    end else if (cmd.res_ok) begin
      res_r <= '0;
    end else if (cmd.handle_commit) begin
      res_r <= '0;
      if ((is_stop || is_query) && !gen_match) begin
        res_r.status <= vsa_pkg::ST_STALE;
      end
    end else if (cmd.pick_commit) begin
      res_r.status             <= vsa_pkg::ST_OK;
      res_r.granted_slot       <= vsa_pkg::SLOT_W'(idx_r);
      res_r.granted_generation <= gen_wdata;
      res_r.stole_voice        <= stole;
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  `VSA_ASSERT(a_emit_into_free, cmd.emit |-> (!out_valid_r || !out_stall), "emit over held beat")
  `VSA_ASSERT(a_scan_bound, scan_r <= CNT_LIM, "scan counter past slot count")
  `VSA_ASSERT(a_pick_sets_active, cmd.pick_commit |=> active_r[$past(idx_r)], "granted slot not active")
  `VSA_ASSERT(a_stop_all_clears, cmd.res_ok |-> (active_r == '0), "voice left active after stop all")
  `VSA_ASSERT_ALWAYS(a_reset_drops_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

@@ hw/rtl/voice_slot_allocator.sv @@
// Play: scans the age and generation of every slot, then writes the chosen slot (no write if all voices loop).
// Stop all: a generation store read-modify-write sweep over every slot.
// Stop, query and finished on an active slot add one generation store read; others answer from decode.
// One request in flight; the next is accepted the cycle after its result enters the output
// register, and an output stall holds off that result and so the next request.
// Synchronous active-low reset clears all flags, generations, play counter and enable.
module voice_slot_allocator #(
  parameter int VOICE_SLOTS = vsa_pkg::VOICE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  vsa_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output vsa_pkg::out_beat_t out_beat
);

  vsa_pkg::cmd_t cmd;
  vsa_pkg::sts_t sts;

  vsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vsa_dp #(
    .VOICE_SLOTS (VOICE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_beat   (in_beat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
